[hdl/ptrs_pkg.sv]
// Package for the pointer table region scanner: sizes, register codes,
// scanner states, configuration struct and the pointer and score helpers.
// No dependencies.
package ptrs_pkg;

  localparam int unsigned MAX_WORDS      = 8192;
  localparam int unsigned ADDR_W         = $clog2(MAX_WORDS);
  localparam int unsigned WL_W           = ADDR_W + 1;
  localparam int unsigned MAX_CANDIDATES = 63;
  localparam int unsigned SPAN_LIMIT     = 1024;

  localparam logic [63:0] PTR_LOW  = 64'h0000_0000_0001_0000;
  localparam logic [63:0] PTR_HIGH = 64'h0000_7FFF_FFFF_FFFF;

  localparam logic [6:0] MIN_CONF_RESET = 7'd70;

  // Register indexes, taken from paddr[4:3]
  localparam logic [1:0] REG_BASE = 2'd0;
  localparam logic [1:0] REG_READ = 2'd1;
  localparam logic [1:0] REG_EXEC = 2'd2;
  localparam logic [1:0] REG_MINC = 2'd3;

  typedef enum logic [3:0] {
    ST_LOAD, ST_CHK, ST_TREQ, ST_TEVAL, ST_TDEC,
    ST_XREQ, ST_XEVAL, ST_SCORE, ST_DECIDE, ST_EMIT, ST_SUMM
  } scan_state_e;

  typedef struct packed {
    logic [63:0] base;
    logic        readable;
    logic        executable;
    logic [6:0]  min_conf;
  } cfg_t;

  function automatic logic ptr_ok(input logic [63:0] p);
    return (p != 64'd0) && (p[2:0] == 3'd0) && (p >= PTR_LOW) && (p <= PTR_HIGH);
  endfunction

  function automatic logic [6:0] score(input logic [10:0] cnt, input logic [13:0] bytes,
                                       input logic [63:0] addr);
    logic [6:0] s;
    s = 7'd0;
    if (cnt >= 11'd4) s = s + 7'd30;
    if (cnt >= 11'd8) s = s + 7'd20;
    if (cnt >= 11'd16) s = s + 7'd20;
    if (bytes >= 14'd64 && bytes <= 14'd4096) s = s + 7'd20;
    if (addr[11:0] == 12'd0) s = s + 7'd10;
    else if (addr[7:0] == 8'd0) s = s + 7'd5;
    return s;
  endfunction

endpackage

[hdl/ptrs_in_if.sv]
// Input channel of the scanner: one region word per transfer.
// No dependencies.
interface ptrs_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] region_word;
  logic        end_of_region;
  modport source(output valid, region_word, end_of_region, input ready);
  modport sink(input valid, region_word, end_of_region, output ready);
endinterface

[hdl/ptrs_out_if.sv]
// Output channel of the scanner: candidate records and region summaries.
// No dependencies.
interface ptrs_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] table_address;
  logic [13:0] table_bytes;
  logic [10:0] pointer_count;
  logic [6:0]  confidence;
  logic [5:0]  found_count;
  logic        rejected;
  logic        dropped;
  logic        last;
  modport source(output valid, kind, table_address, table_bytes, pointer_count,
                 confidence, found_count, rejected, dropped, last, input ready);
  modport sink(input valid, kind, table_address, table_bytes, pointer_count,
               confidence, found_count, rejected, dropped, last, output ready);
endinterface

[hdl/pointer_table_region_scanner.sv]
// Top level of the pointer table region scanner: APB configuration registers
// and the scan engine. Depends on ptrs_pkg, ptrs_in_if, ptrs_out_if, ptrs_core.
//
// Usage: write region_base (0x00), region_readable (0x08), region_executable
// (0x10) and min_confidence (0x18) over APB while idle, then stream the region
// words on in_ch, one transfer per cycle, with end_of_region on the last one.
// Words beyond 8192 are not stored and make the region rejected.
// After the last word the sequencer scans the flag memory, each entry read
// taking a request state and an evaluate state. Each offset with at least 8
// words left takes a check state, up to 32 reads for the density and run tests
// and a decision state; an offset that passes adds up to 1025 reads to extend
// the run, the score and decide states, and the emit state to load a reported
// candidate. Each reported run is one candidate transfer on out_ch, and a
// summary transfer with last set closes the region; a rejected region goes
// from the check state straight to the summary state.
// in_ch is ready only while loading; a stalled out_ch holds the scan at its
// next result, and a waiting summary does not block loading of the next
// region. Reset empties the region state and sets min_confidence to 70.
module pointer_table_region_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptrs_in_if.sink     in_ch,
  ptrs_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  ptrs_pkg::cfg_t cfg_q;
  logic [1:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx = paddr[4:3];
  assign wr = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base <= '0;
      cfg_q.readable <= 1'b0;
      cfg_q.executable <= 1'b0;
      cfg_q.min_conf <= ptrs_pkg::MIN_CONF_RESET;
    end else if (wr) begin
      case (idx)
        ptrs_pkg::REG_BASE: cfg_q.base <= pwdata;
        ptrs_pkg::REG_READ: cfg_q.readable <= pwdata[0];
        ptrs_pkg::REG_EXEC: cfg_q.executable <= pwdata[0];
        ptrs_pkg::REG_MINC: cfg_q.min_conf <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (idx)
      ptrs_pkg::REG_BASE: prdata = cfg_q.base;
      ptrs_pkg::REG_READ: prdata = {63'd0, cfg_q.readable};
      ptrs_pkg::REG_EXEC: prdata = {63'd0, cfg_q.executable};
      ptrs_pkg::REG_MINC: prdata = {57'd0, cfg_q.min_conf};
      default: prdata = '0;
    endcase
  end

  ptrs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

[hdl/ptrs_core.sv]
// Scan engine: word flag memory, scan sequencer and output register.
// Depends on ptrs_pkg, ptrs_in_if and ptrs_out_if.
module ptrs_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ptrs_pkg::cfg_t       cfg_i,
  ptrs_in_if.sink              in_ch,
  ptrs_out_if.source           out_ch
);

  // Flag memory: bit 1 = zero word, bit 0 = valid pointer
  logic [1:0] mem [ptrs_pkg::MAX_WORDS];
  logic [1:0] rd_q;
  logic [ptrs_pkg::ADDR_W-1:0] rd_addr;

  ptrs_pkg::scan_state_e state_q, state_d;
  logic [ptrs_pkg::WL_W-1:0] wl_q, wl_d, n_q, n_d, w_q, w_d, i_q, i_d;
  logic        rej_q, rej_d, drop_q, drop_d;
  logic [5:0]  emitted_q, emitted_d;
  logic [5:0]  j_q, j_d, cnt_q, cnt_d;
  logic [4:0]  run_q, run_d;
  logic        hit_q, hit_d;
  logic [10:0] d_q, d_d, ecnt_q, ecnt_d, span_q, span_d;
  logic [13:0] bytes_q, bytes_d;
  logic [63:0] addr_q, addr_d;
  logic [6:0]  conf_q, conf_d;

  logic out_valid_q, out_load_cand, out_load_summ;
  logic wr_en;

  logic [ptrs_pkg::WL_W-1:0] rest;
  logic [5:0]  win32;
  logic [4:0]  win16;
  logic        fv, fz;
  logic [10:0] ecnt_n, sp;
  logic [6:0]  conf_c;
  logic        stop;

  assign rest  = n_q - w_q;
  assign win32 = (rest < 14'd32) ? rest[5:0] : 6'd32;
  assign win16 = (rest < 14'd16) ? rest[4:0] : 5'd16;
  assign fv    = rd_q[0];
  assign fz    = rd_q[1];
  assign sp    = (span_q == 11'd0) ? ecnt_q : span_q;
  assign conf_c = ptrs_pkg::score(ecnt_q, bytes_q, addr_q);

  assign in_ch.ready = (state_q == ptrs_pkg::ST_LOAD);
  assign wr_en = in_ch.valid && in_ch.ready && (wl_q < 14'(ptrs_pkg::MAX_WORDS));

  // Store word flags and read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wl_q[ptrs_pkg::ADDR_W-1:0]] <= {in_ch.region_word == 64'd0,
                                         ptrs_pkg::ptr_ok(in_ch.region_word)};
    end
    rd_q <= mem[rd_addr];
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    wl_d = wl_q; n_d = n_q; w_d = w_q; i_d = i_q;
    rej_d = rej_q; drop_d = drop_q; emitted_d = emitted_q;
    j_d = j_q; cnt_d = cnt_q; run_d = run_q; hit_d = hit_q;
    d_d = d_q; ecnt_d = ecnt_q; span_d = span_q;
    bytes_d = bytes_q; addr_d = addr_q; conf_d = conf_q;
    rd_addr = i_q[ptrs_pkg::ADDR_W-1:0];
    out_load_cand = 1'b0;
    out_load_summ = 1'b0;
    ecnt_n = ecnt_q;
    stop = 1'b0;
    case (state_q)
      ptrs_pkg::ST_LOAD: begin
        if (in_ch.valid) begin
          if (wl_q < 14'(ptrs_pkg::MAX_WORDS)) wl_d = wl_q + 14'd1;
          else wl_d = 14'(ptrs_pkg::MAX_WORDS + 1);
          if (in_ch.end_of_region) begin
            n_d = wl_d;
            rej_d = !(cfg_i.readable && !cfg_i.executable && wl_d >= 14'd8 &&
                      wl_d <= 14'(ptrs_pkg::MAX_WORDS));
            w_d = '0;
            state_d = ptrs_pkg::ST_CHK;
          end
        end
      end
      ptrs_pkg::ST_CHK: begin
        j_d = '0; cnt_d = '0; run_d = '0; hit_d = 1'b0;
        if (!rej_q && ({1'b0, w_q} + 15'd8 <= {1'b0, n_q})) state_d = ptrs_pkg::ST_TREQ;
        else state_d = ptrs_pkg::ST_SUMM;
      end
      ptrs_pkg::ST_TREQ: begin
        rd_addr = w_q[ptrs_pkg::ADDR_W-1:0] + {7'd0, j_q};
        state_d = ptrs_pkg::ST_TEVAL;
      end
      ptrs_pkg::ST_TEVAL: begin
        if (fv) cnt_d = cnt_q + 6'd1;
        if (j_q < {1'b0, win16}) begin
          if (fv) begin
            run_d = run_q + 5'd1;
            if (run_q >= 5'd3) hit_d = 1'b1;
          end else begin
            run_d = '0;
          end
        end
        j_d = j_q + 6'd1;
        state_d = (j_q + 6'd1 == win32) ? ptrs_pkg::ST_TDEC : ptrs_pkg::ST_TREQ;
      end
      ptrs_pkg::ST_TDEC: begin
        if (({3'd0, cnt_q} * 9'd5 >= {3'd0, win32} * 9'd3) && (hit_q || run_q >= 5'd3)) begin
          i_d = w_q; d_d = '0; ecnt_d = '0; span_d = '0;
          state_d = ptrs_pkg::ST_XREQ;
        end else begin
          w_d = w_q + 14'd1;
          state_d = ptrs_pkg::ST_CHK;
        end
      end
      ptrs_pkg::ST_XREQ: begin
        rd_addr = i_q[ptrs_pkg::ADDR_W-1:0];
        state_d = ptrs_pkg::ST_XEVAL;
      end
      ptrs_pkg::ST_XEVAL: begin
        if (fz) begin
          stop = 1'b1; span_d = d_q;
        end else begin
          if (fv) ecnt_n = ecnt_q + 11'd1;
          else if (ecnt_q >= 11'd4) begin
            stop = 1'b1; span_d = d_q;
          end
          if (!stop && d_q >= 11'(ptrs_pkg::SPAN_LIMIT)) begin
            stop = 1'b1; span_d = d_q;
          end
        end
        ecnt_d = ecnt_n;
        if (stop) state_d = ptrs_pkg::ST_SCORE;
        else if (i_q + 14'd1 == n_q) begin
          span_d = '0; state_d = ptrs_pkg::ST_SCORE;
        end else begin
          i_d = i_q + 14'd1; d_d = d_q + 11'd1;
          state_d = ptrs_pkg::ST_XREQ;
        end
      end
      ptrs_pkg::ST_SCORE: begin
        bytes_d = {sp, 3'b000};
        addr_d = cfg_i.base + {47'd0, w_q, 3'b000};
        state_d = ptrs_pkg::ST_DECIDE;
      end
      ptrs_pkg::ST_DECIDE: begin
        conf_d = conf_c;
        w_d = w_q + {3'd0, bytes_q[13:3]} + 14'd1;
        state_d = ptrs_pkg::ST_CHK;
        if (conf_c >= cfg_i.min_conf) begin
          if (emitted_q < 6'(ptrs_pkg::MAX_CANDIDATES)) state_d = ptrs_pkg::ST_EMIT;
          else drop_d = 1'b1;
        end
      end
      ptrs_pkg::ST_EMIT: begin
        if (!out_valid_q) begin
          out_load_cand = 1'b1;
          emitted_d = emitted_q + 6'd1;
          state_d = ptrs_pkg::ST_CHK;
        end
      end
      ptrs_pkg::ST_SUMM: begin
        if (!out_valid_q) begin
          out_load_summ = 1'b1;
          wl_d = '0; emitted_d = '0; drop_d = 1'b0;
          state_d = ptrs_pkg::ST_LOAD;
        end
      end
      default: state_d = ptrs_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptrs_pkg::ST_LOAD;
      wl_q <= '0; emitted_q <= '0; drop_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wl_q <= wl_d; emitted_q <= emitted_d; drop_q <= drop_d;
      if (out_load_cand || out_load_summ) out_valid_q <= 1'b1;
      else if (out_ch.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; w_q <= w_d; i_q <= i_d; rej_q <= rej_d;
    j_q <= j_d; cnt_q <= cnt_d; run_q <= run_d; hit_q <= hit_d;
    d_q <= d_d; ecnt_q <= ecnt_d; span_q <= span_d;
    bytes_q <= bytes_d; addr_q <= addr_d; conf_q <= conf_d;
  end

  // Output register: load a candidate or a summary
  always_ff @(posedge clk_i) begin
    if (out_load_cand) begin
      out_ch.kind <= 1'b0;
      out_ch.table_address <= addr_q;
      out_ch.table_bytes <= bytes_q;
      out_ch.pointer_count <= ecnt_q;
      out_ch.confidence <= conf_q;
      out_ch.found_count <= '0;
      out_ch.rejected <= 1'b0;
      out_ch.dropped <= 1'b0;
      out_ch.last <= 1'b0;
    end else if (out_load_summ) begin
      out_ch.kind <= 1'b1;
      out_ch.table_address <= '0;
      out_ch.table_bytes <= '0;
      out_ch.pointer_count <= '0;
      out_ch.confidence <= '0;
      out_ch.found_count <= emitted_q;
      out_ch.rejected <= rej_q;
      out_ch.dropped <= drop_q;
      out_ch.last <= 1'b1;
    end
  end

  assign out_ch.valid = out_valid_q;

  a_emit_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitted_q <= 6'(ptrs_pkg::MAX_CANDIDATES)) else $error("candidate count over limit");
  a_load_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wl_q <= 14'(ptrs_pkg::MAX_WORDS + 1)) else $error("load count over limit");
  a_load_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load_cand || out_load_summ) |-> !out_valid_q) else $error("output overwritten");
  a_summ_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_summ |=> (wl_q == '0 && emitted_q == '0)) else $error("region state not cleared");

endmodule
